[rtl/vi_pkg.sv]
// ----------------------------------------------------------------------------
// vi_pkg: shared constants for the vortex indicator window
// Fixed field widths, fixed-point format, register map and parameter defaults.
// ----------------------------------------------------------------------------
package vi_pkg;

   // parameter defaults
   localparam int MAX_PERIOD_DEF = 64;
   localparam int PRICE_BITS_DEF = 32;

   // ratio format: unsigned Q8.16, trend signed one bit wider
   localparam int Q_BITS     = 24;
   localparam int FRAC_BITS  = 16;
   localparam int INT_BITS   = Q_BITS - FRAC_BITS;
   localparam int TREND_BITS = Q_BITS + 1;

   // window register
   localparam int                     WINDOW_BITS  = 7;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd14;

   // register port
   localparam int   CSR_ADDR_BITS = 3;
   localparam int   CSR_DATA_BITS = 32;
   localparam logic REG_WINDOW    = 1'b0;

endpackage

[rtl/vi_req_if.sv]
// ----------------------------------------------------------------------------
// vi_req_if: price bar channel
// Valid/ready channel carrying one bar (high, low, close) per beat.
// ----------------------------------------------------------------------------
interface vi_req_if
   import vi_pkg::*;
#(
   parameter int PRICE_BITS = PRICE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] high_price;
   logic [PRICE_BITS-1:0] low_price;
   logic [PRICE_BITS-1:0] close_price;

   modport source (output valid, output high_price, output low_price,
                   output close_price, input ready);
   modport sink   (input valid, input high_price, input low_price,
                   input close_price, output ready);
endinterface

[rtl/vi_rsp_if.sv]
// ----------------------------------------------------------------------------
// vi_rsp_if: indicator result channel
// Valid/ready channel carrying VI+, VI-, trend and the valid flag per beat.
// ----------------------------------------------------------------------------
interface vi_rsp_if
   import vi_pkg::*;
;
   logic                         valid;
   logic                         ready;
   logic [Q_BITS-1:0]            plus_index;
   logic [Q_BITS-1:0]            minus_index;
   logic signed [TREND_BITS-1:0] trend_value;
   logic                         ratio_valid;

   modport source (output valid, output plus_index, output minus_index,
                   output trend_value, output ratio_valid, input ready);
   modport sink   (input valid, input plus_index, input minus_index,
                   input trend_value, input ratio_valid, output ready);
endinterface

[rtl/vortex_indicator_window.sv]
// Steps: a first bar goes straight to the result; a later bar runs difference, write, a
// sweep of usable = min(window, MAX_PERIOD, bars seen - 1) entries, drain, check, divide.
// Divide is skipped on a zero range sum and cut short when both ratios saturate. Bars go
// one at a time; the next is taken once the result has moved into the output register.
// The sweep (one entry per cycle) and the 24-step bit-serial dividers set the pace.
// Reset: synchronous, clears bar count, pointer and handshakes; history needs no clear.
// ----------------------------------------------------------------------------
// vortex_indicator_window: vortex indicator over a sliding window of bars
// Movement and range history in memory, summed per bar, ratios by two
// bit-serial dividers running side by side.
// ----------------------------------------------------------------------------
module vortex_indicator_window
   import vi_pkg::*;
#(
   parameter int MAX_PERIOD = MAX_PERIOD_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   vi_req_if.sink                   req_bus,
   vi_rsp_if.source                 rsp_bus,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);
   localparam int AW       = $clog2(MAX_PERIOD);
   localparam int CNT_BITS = $clog2(MAX_PERIOD + 2);
   localparam int SUM_BITS = PRICE_BITS + $clog2(MAX_PERIOD);
   localparam int CMP_BITS = (CNT_BITS > WINDOW_BITS) ? CNT_BITS : WINDOW_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIFF  = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_SWEEP = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [WINDOW_BITS-1:0] window_length;

   // control state
   logic [2:0]          state_ff,      state_in;
   logic [CNT_BITS-1:0] bars_seen_ff,  bars_seen_in;
   logic [CNT_BITS-1:0] usable_ff,     usable_in;
   logic [CNT_BITS-1:0] count_ff,      count_in;
   logic [AW-1:0]       ptr_ff,        ptr_in;
   logic [AW-1:0]       rd_addr_ff,    rd_addr_in;
   logic                acc_valid_ff,  acc_valid_in;
   logic                rsp_valid_ff,  rsp_valid_in;

   // payload
   logic [PRICE_BITS-1:0] bar_high_ff,   bar_high_in;
   logic [PRICE_BITS-1:0] bar_low_ff,    bar_low_in;
   logic [PRICE_BITS-1:0] bar_close_ff,  bar_close_in;
   logic [PRICE_BITS-1:0] prev_high_ff,  prev_high_in;
   logic [PRICE_BITS-1:0] prev_low_ff,   prev_low_in;
   logic [PRICE_BITS-1:0] prev_close_ff, prev_close_in;
   logic [PRICE_BITS-1:0] d_plus_ff,     d_plus_in;
   logic [PRICE_BITS-1:0] d_minus_ff,    d_minus_in;
   logic [PRICE_BITS-1:0] d_hc_ff,       d_hc_in;
   logic [PRICE_BITS-1:0] d_lc_ff,       d_lc_in;
   logic [PRICE_BITS-1:0] d_hl_ff,       d_hl_in;
   logic                  hl_pos_ff,     hl_pos_in;
   logic [SUM_BITS-1:0]   plus_sum_ff,   plus_sum_in;
   logic [SUM_BITS-1:0]   minus_sum_ff,  minus_sum_in;
   logic [SUM_BITS-1:0]   range_sum_ff,  range_sum_in;
   logic [Q_BITS-1:0]     res_plus_ff,   res_plus_in;
   logic [Q_BITS-1:0]     res_minus_ff,  res_minus_in;
   logic                  res_valid_ff,  res_valid_in;
   logic [Q_BITS-1:0]     out_plus_ff,   out_plus_in;
   logic [Q_BITS-1:0]     out_minus_ff,  out_minus_in;
   logic [TREND_BITS-1:0] out_trend_ff,  out_trend_in;
   logic                  out_valid_ff,  out_valid_in;

   // datapath helpers
   logic [PRICE_BITS-1:0] tr_pick;
   logic [PRICE_BITS-1:0] true_range;
   logic [CMP_BITS-1:0]   win_ext;
   logic [CMP_BITS-1:0]   win_clamp;
   logic [CMP_BITS-1:0]   seen_ext;
   logic [CMP_BITS-1:0]   usable_ext;
   logic                  hist_wr_en;
   logic                  hist_rd_en;
   logic [PRICE_BITS-1:0] hist_plus;
   logic [PRICE_BITS-1:0] hist_minus;
   logic [PRICE_BITS-1:0] hist_range;
   logic                  div_start;
   logic                  plus_done;
   logic                  minus_done;
   logic [Q_BITS-1:0]     plus_quo;
   logic [Q_BITS-1:0]     minus_quo;
   logic                  req_beat;
   logic                  rsp_free;

   vi_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .window_length (window_length)
   );

   vi_history #(
      .DEPTH      (MAX_PERIOD),
      .PRICE_BITS (PRICE_BITS),
      .AW         (AW)
   ) u_history (
      .clock    (clock),
      .wr_en    (hist_wr_en),
      .wr_addr  (ptr_ff),
      .wr_plus  (d_plus_ff),
      .wr_minus (d_minus_ff),
      .wr_range (true_range),
      .rd_en    (hist_rd_en),
      .rd_addr  (rd_addr_ff),
      .rd_plus  (hist_plus),
      .rd_minus (hist_minus),
      .rd_range (hist_range)
   );

   vi_divider #(
      .NUM_BITS (SUM_BITS)
   ) u_div_plus (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (plus_sum_ff),
      .denom    (range_sum_ff),
      .done     (plus_done),
      .quotient (plus_quo)
   );

   vi_divider #(
      .NUM_BITS (SUM_BITS)
   ) u_div_minus (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (minus_sum_ff),
      .denom    (range_sum_ff),
      .done     (minus_done),
      .quotient (minus_quo)
   );

   // handshakes
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_beat      = req_bus.valid && (state_ff == S_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   assign hist_wr_en = (state_ff == S_WRITE);
   assign hist_rd_en = (state_ff == S_SWEEP);
   assign div_start  = (state_ff == S_CHECK) && (range_sum_ff != '0);

   // true range: larger close gap, then high minus low when positive
   assign tr_pick    = (d_lc_ff > d_hc_ff) ? d_lc_ff : d_hc_ff;
   assign true_range = (hl_pos_ff && (d_hl_ff > tr_pick)) ? d_hl_ff : tr_pick;

   // usable = min(clamped window, bars seen, MAX_PERIOD)
   always_comb begin
      win_ext  = CMP_BITS'(window_length);
      seen_ext = CMP_BITS'(bars_seen_ff);
      if (win_ext == '0) begin
         win_clamp = CMP_BITS'(1);
      end else if (win_ext > CMP_BITS'(MAX_PERIOD)) begin
         win_clamp = CMP_BITS'(MAX_PERIOD);
      end else begin
         win_clamp = win_ext;
      end
      if (seen_ext > CMP_BITS'(MAX_PERIOD)) begin
         seen_ext = CMP_BITS'(MAX_PERIOD);
      end
      usable_ext = (seen_ext < win_clamp) ? seen_ext : win_clamp;
   end

   always_comb begin
      state_in      = state_ff;
      bars_seen_in  = bars_seen_ff;
      usable_in     = usable_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      rd_addr_in    = rd_addr_ff;
      acc_valid_in  = (state_ff == S_SWEEP);
      rsp_valid_in  = rsp_valid_ff;
      bar_high_in   = bar_high_ff;
      bar_low_in    = bar_low_ff;
      bar_close_in  = bar_close_ff;
      prev_high_in  = prev_high_ff;
      prev_low_in   = prev_low_ff;
      prev_close_in = prev_close_ff;
      d_plus_in     = d_plus_ff;
      d_minus_in    = d_minus_ff;
      d_hc_in       = d_hc_ff;
      d_lc_in       = d_lc_ff;
      d_hl_in       = d_hl_ff;
      hl_pos_in     = hl_pos_ff;
      plus_sum_in   = plus_sum_ff;
      minus_sum_in  = minus_sum_ff;
      range_sum_in  = range_sum_ff;
      res_plus_in   = res_plus_ff;
      res_minus_in  = res_minus_ff;
      res_valid_in  = res_valid_ff;
      out_plus_in   = out_plus_ff;
      out_minus_in  = out_minus_ff;
      out_trend_in  = out_trend_ff;
      out_valid_in  = out_valid_ff;

      // drop a result beat once taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      // accumulate the entry read in the previous cycle
      if (acc_valid_ff) begin
         plus_sum_in  = plus_sum_ff  + SUM_BITS'(hist_plus);
         minus_sum_in = minus_sum_ff + SUM_BITS'(hist_minus);
         range_sum_in = range_sum_ff + SUM_BITS'(hist_range);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               bar_high_in  = req_bus.high_price;
               bar_low_in   = req_bus.low_price;
               bar_close_in = req_bus.close_price;
               usable_in    = CNT_BITS'(usable_ext);
               if (bars_seen_ff != CNT_BITS'(MAX_PERIOD + 1)) begin
                  bars_seen_in = bars_seen_ff + CNT_BITS'(1);
               end
               if (bars_seen_ff == '0) begin
                  // first bar: store it, report zeros
                  prev_high_in  = req_bus.high_price;
                  prev_low_in   = req_bus.low_price;
                  prev_close_in = req_bus.close_price;
                  res_plus_in   = '0;
                  res_minus_in  = '0;
                  res_valid_in  = 1'b0;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_DIFF;
               end
            end
         end
         S_DIFF: begin
            // movements and range candidates against the previous bar
            d_plus_in  = (bar_high_ff >= prev_low_ff) ? bar_high_ff - prev_low_ff
                                                      : prev_low_ff - bar_high_ff;
            d_minus_in = (bar_low_ff >= prev_high_ff) ? bar_low_ff - prev_high_ff
                                                      : prev_high_ff - bar_low_ff;
            d_hc_in    = (bar_high_ff >= prev_close_ff) ? bar_high_ff - prev_close_ff
                                                        : prev_close_ff - bar_high_ff;
            d_lc_in    = (bar_low_ff >= prev_close_ff) ? bar_low_ff - prev_close_ff
                                                       : prev_close_ff - bar_low_ff;
            d_hl_in    = bar_high_ff - bar_low_ff;
            hl_pos_in  = (bar_high_ff > bar_low_ff);
            prev_high_in  = bar_high_ff;
            prev_low_in   = bar_low_ff;
            prev_close_in = bar_close_ff;
            state_in      = S_WRITE;
         end
         S_WRITE: begin
            // store the entry, start the sweep at it
            rd_addr_in   = ptr_ff;
            ptr_in       = (ptr_ff == AW'(MAX_PERIOD - 1)) ? '0 : ptr_ff + AW'(1);
            count_in     = '0;
            plus_sum_in  = '0;
            minus_sum_in = '0;
            range_sum_in = '0;
            state_in     = S_SWEEP;
         end
         S_SWEEP: begin
            // walk back through the most recent entries
            rd_addr_in = (rd_addr_ff == '0) ? AW'(MAX_PERIOD - 1) : rd_addr_ff - AW'(1);
            count_in   = count_ff + CNT_BITS'(1);
            if (count_ff == usable_ff - CNT_BITS'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (range_sum_ff == '0) begin
               res_plus_in  = '0;
               res_minus_in = '0;
               res_valid_in = 1'b0;
               state_in     = S_DONE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (plus_done && minus_done) begin
               res_plus_in  = plus_quo;
               res_minus_in = minus_quo;
               res_valid_in = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (rsp_free) begin
               out_plus_in  = res_plus_ff;
               out_minus_in = res_minus_ff;
               out_trend_in = {1'b0, res_plus_ff} - {1'b0, res_minus_ff};
               out_valid_in = res_valid_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bars_seen_ff  <= '0;
         usable_ff     <= '0;
         count_ff      <= '0;
         ptr_ff        <= '0;
         rd_addr_ff    <= '0;
         acc_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_high_ff  <= '0;
         prev_low_ff   <= '0;
         prev_close_ff <= '0;
      end else begin
         state_ff      <= state_in;
         bars_seen_ff  <= bars_seen_in;
         usable_ff     <= usable_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         rd_addr_ff    <= rd_addr_in;
         acc_valid_ff  <= acc_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_high_ff  <= prev_high_in;
         prev_low_ff   <= prev_low_in;
         prev_close_ff <= prev_close_in;
      end
   end

   always_ff @(posedge clock) begin
      bar_high_ff  <= bar_high_in;
      bar_low_ff   <= bar_low_in;
      bar_close_ff <= bar_close_in;
      d_plus_ff    <= d_plus_in;
      d_minus_ff   <= d_minus_in;
      d_hc_ff      <= d_hc_in;
      d_lc_ff      <= d_lc_in;
      d_hl_ff      <= d_hl_in;
      hl_pos_ff    <= hl_pos_in;
      plus_sum_ff  <= plus_sum_in;
      minus_sum_ff <= minus_sum_in;
      range_sum_ff <= range_sum_in;
      res_plus_ff  <= res_plus_in;
      res_minus_ff <= res_minus_in;
      res_valid_ff <= res_valid_in;
      out_plus_ff  <= out_plus_in;
      out_minus_ff <= out_minus_in;
      out_trend_ff <= out_trend_in;
      out_valid_ff <= out_valid_in;
   end

   // result beat
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.plus_index  = out_plus_ff;
   assign rsp_bus.minus_index = out_minus_ff;
   assign rsp_bus.trend_value = out_trend_ff;
   assign rsp_bus.ratio_valid = out_valid_ff;
endmodule

[rtl/vi_csr.sv]
// ----------------------------------------------------------------------------
// vi_csr: configuration register block
// APB-style write/read of the window length register.
// ----------------------------------------------------------------------------
module vi_csr
   import vi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [WINDOW_BITS-1:0]   window_length
);
   logic                   reg_index;
   logic                   write_hit;
   logic [WINDOW_BITS-1:0] window_ff;
   logic [WINDOW_BITS-1:0] window_in;

   // decode the word index, ignore byte offset
   assign reg_index = paddr[CSR_ADDR_BITS-1];
   assign write_hit = psel && penable && pwrite && (reg_index == REG_WINDOW);
   assign pready    = 1'b1;

   // take the low bits of the written word
   always_comb begin
      window_in = window_ff;
      if (write_hit) begin
         window_in = pwdata[WINDOW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (reg_index == REG_WINDOW) begin
         prdata = {{(CSR_DATA_BITS-WINDOW_BITS){1'b0}}, window_ff};
      end
   end

   assign window_length = window_ff;
endmodule

[rtl/vi_history.sv]
// ----------------------------------------------------------------------------
// vi_history: movement and range history memory
// One write port and one registered read port over MAX_PERIOD entries.
// ----------------------------------------------------------------------------
module vi_history
   import vi_pkg::*;
#(
   parameter int DEPTH      = MAX_PERIOD_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF,
   parameter int AW         = $clog2(DEPTH)
)
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [PRICE_BITS-1:0] wr_plus,
   input  logic [PRICE_BITS-1:0] wr_minus,
   input  logic [PRICE_BITS-1:0] wr_range,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [PRICE_BITS-1:0] rd_plus,
   output logic [PRICE_BITS-1:0] rd_minus,
   output logic [PRICE_BITS-1:0] rd_range
);
   localparam int WORD_BITS = 3 * PRICE_BITS;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_word_ff;

   // store one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_plus, wr_minus, wr_range};
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_plus  = rd_word_ff[WORD_BITS-1 -: PRICE_BITS];
   assign rd_minus = rd_word_ff[2*PRICE_BITS-1 -: PRICE_BITS];
   assign rd_range = rd_word_ff[PRICE_BITS-1:0];
endmodule

[rtl/vi_divider.sv]
// ----------------------------------------------------------------------------
// vi_divider: bit-serial Q8.16 divider
// Restoring division, one quotient bit per cycle, saturating at full scale.
// ----------------------------------------------------------------------------
module vi_divider
   import vi_pkg::*;
#(
   parameter int NUM_BITS = PRICE_BITS_DEF + $clog2(MAX_PERIOD_DEF)
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [NUM_BITS-1:0] denom,
   output logic                done,
   output logic [Q_BITS-1:0]   quotient
);
   localparam int STEP_BITS = $clog2(Q_BITS);

   localparam logic [1:0] D_IDLE  = 2'd0;
   localparam logic [1:0] D_CHECK = 2'd1;
   localparam logic [1:0] D_RUN   = 2'd2;

   logic [1:0]           state_ff,  state_in;
   logic                 done_ff,   done_in;
   logic [STEP_BITS-1:0] step_ff,   step_in;
   logic [NUM_BITS-1:0]  rem_ff,    rem_in;
   logic [NUM_BITS-1:0]  den_ff,    den_in;
   logic [Q_BITS-1:0]    digit_ff,  digit_in;
   logic [Q_BITS-1:0]    quo_ff,    quo_in;
   logic [NUM_BITS:0]    shifted;
   logic [NUM_BITS:0]    trial;
   logic                 fits;

   // shift in the next dividend bit and try a subtract
   assign shifted = {rem_ff, digit_ff[Q_BITS-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      digit_in = digit_ff;
      quo_in   = quo_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               rem_in   = NUM_BITS'(numer >> INT_BITS);
               den_in   = denom;
               digit_in = {numer[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
               done_in  = 1'b0;
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            // whole part of 256 or more: saturate
            if (rem_ff >= den_ff) begin
               quo_in   = '1;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               step_in  = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (fits) begin
               rem_in = trial[NUM_BITS-1:0];
            end else begin
               rem_in = shifted[NUM_BITS-1:0];
            end
            quo_in   = {quo_ff[Q_BITS-2:0], fits};
            digit_in = {digit_ff[Q_BITS-2:0], 1'b0};
            step_in  = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(Q_BITS - 1)) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      digit_ff <= digit_in;
      quo_ff   <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[tb/sv/vortex_indicator_window_tb.sv]
// ----------------------------------------------------------------------------
// vortex_indicator_window_tb: self-checking bench for the vortex indicator
// Drives price bars through the request channel in bursts, predicts VI+, VI-,
// trend and the valid flag for every accepted bar from a behavioural copy of
// the block, and checks each response beat in order. The window register is
// rewritten between phases across its whole range, the extremes included.
// ----------------------------------------------------------------------------
module vortex_indicator_window_tb;
   import vi_pkg::*;

   localparam int RING_DEPTH  = 64;
   localparam int BAR_LIMIT   = RING_DEPTH + 1;
   localparam int PHASE_BARS  = 100;
   localparam int SETTLE_WAIT = 120;
   localparam logic [CSR_ADDR_BITS-1:0] WINDOW_ADDR = CSR_ADDR_BITS'(4 * REG_WINDOW);

   typedef struct packed {
      logic [31:0] high_price;
      logic [31:0] low_price;
      logic [31:0] close_price;
   } bar_type;

   typedef struct packed {
      logic [Q_BITS-1:0]     plus_index;
      logic [Q_BITS-1:0]     minus_index;
      logic [TREND_BITS-1:0] trend_value;
      logic                  ratio_valid;
   } vi_result_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   vi_req_if #(.PRICE_BITS(32)) req_bus ();
   vi_rsp_if                    rsp_bus ();

   vortex_indicator_window #(.MAX_PERIOD(RING_DEPTH), .PRICE_BITS(32)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // indicator state mirrored on the bench side
   logic [WINDOW_BITS-1:0] window_setting = WINDOW_RESET;
   logic [31:0]            prior_high     = '0;
   logic [31:0]            prior_low      = '0;
   logic [31:0]            prior_close    = '0;
   int                     bar_count      = 0;
   logic [31:0]            plus_ring  [RING_DEPTH];
   logic [31:0]            minus_ring [RING_DEPTH];
   logic [31:0]            range_ring [RING_DEPTH];
   logic [5:0]             ring_head      = '0;

   bar_type        pending_bars [$];
   vi_result_type  expected_ratios [$];
   int             bars_unaccepted = 0;
   int             mismatch_count  = 0;
   logic           bar_taken       = 1'b0;
   logic [31:0]    walk_close      = 32'd100000;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic logic [31:0] gap32(input logic [31:0] a, input logic [31:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // unsigned Q8.16 quotient, truncated, saturated once the whole part hits 256
   function automatic logic [Q_BITS-1:0] ratio_q816(input logic [37:0] num,
                                                    input logic [37:0] den);
      logic [63:0] num_wide;
      logic [63:0] den_wide;
      num_wide = {26'b0, num};
      den_wide = {26'b0, den};
      if (num_wide / den_wide >= 64'd256) begin
         return '1;
      end
      return Q_BITS'((num_wide << FRAC_BITS) / den_wide);
   endfunction

   function automatic vi_result_type advance_vortex(input bar_type b);
      vi_result_type r;
      logic [31:0]   true_range;
      logic [31:0]   close_gap;
      logic [37:0]   plus_total;
      logic [37:0]   minus_total;
      logic [37:0]   range_total;
      logic [5:0]    slot;
      int            win;
      int            span;
      r = '0;
      if (bar_count > 0) begin
         true_range = gap32(b.high_price, prior_close);
         close_gap  = gap32(b.low_price, prior_close);
         if (close_gap > true_range) begin
            true_range = close_gap;
         end
         // an inverted bar never wins on its own high - low
         if (b.high_price > b.low_price && b.high_price - b.low_price > true_range) begin
            true_range = b.high_price - b.low_price;
         end
         plus_ring[ring_head]  = gap32(b.high_price, prior_low);
         minus_ring[ring_head] = gap32(b.low_price, prior_high);
         range_ring[ring_head] = true_range;
         ring_head = ring_head + 6'd1;

         // clamp the window, then never reach past the entries written so far
         win = int'(window_setting);
         if (win < 1) begin
            win = 1;
         end
         if (win > RING_DEPTH) begin
            win = RING_DEPTH;
         end
         span = (bar_count > RING_DEPTH) ? RING_DEPTH : bar_count;
         if (span > win) begin
            span = win;
         end

         plus_total  = '0;
         minus_total = '0;
         range_total = '0;
         for (int k = 0; k < span; k++) begin
            slot = ring_head - 6'(k + 1);
            plus_total  = plus_total + 38'(plus_ring[slot]);
            minus_total = minus_total + 38'(minus_ring[slot]);
            range_total = range_total + 38'(range_ring[slot]);
         end

         if (range_total != '0) begin
            r.plus_index  = ratio_q816(plus_total, range_total);
            r.minus_index = ratio_q816(minus_total, range_total);
            r.trend_value = {1'b0, r.plus_index} - {1'b0, r.minus_index};
            r.ratio_valid = 1'b1;
         end
      end
      prior_high  = b.high_price;
      prior_low   = b.low_price;
      prior_close = b.close_price;
      if (bar_count < BAR_LIMIT) begin
         bar_count++;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void queue_bar(input logic [31:0] h, input logic [31:0] l,
                                     input logic [31:0] c);
      pending_bars.push_back('{h, l, c});
      bars_unaccepted++;
   endfunction

   function automatic logic [31:0] clamp_price(input longint p);
      if (p < 0) begin
         return '0;
      end
      if (p > 64'hFFFF_FFFF) begin
         return '1;
      end
      return 32'(p);
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return walk_close;
         default: return $urandom();
      endcase
   endfunction

   // mostly a random walk of plausible bars; some flat stretches, noise and field extremes
   function automatic bar_type random_bar();
      bar_type b;
      int      pick;
      longint  spread;
      longint  c;
      pick   = $urandom_range(0, 99);
      spread = longint'(1) << $urandom_range(0, 24);
      if ($urandom_range(0, 49) == 0) begin
         walk_close = $urandom();
      end
      if (pick < 72) begin
         c = longint'(walk_close) + longint'($urandom_range(0, 32'(2 * spread))) - spread;
         walk_close = clamp_price(c);
         b.close_price = walk_close;
         b.high_price  = clamp_price(longint'(walk_close) + $urandom_range(0, 32'(spread)));
         b.low_price   = clamp_price(longint'(walk_close) - $urandom_range(0, 32'(spread)));
      end else if (pick < 80) begin
         b = '{walk_close, walk_close, walk_close};
      end else if (pick < 92) begin
         b = '{$urandom(), $urandom(), $urandom()};
      end else begin
         b = '{pick_extreme(), pick_extreme(), pick_extreme()};
      end
      return b;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
      end
   endtask

   // hold until every bar is taken and every response beat has come back
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (bars_unaccepted != 0 || expected_ratios.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // write the window over APB, then read it back
   task automatic write_window(input int value);
      logic [CSR_DATA_BITS-1:0] readback;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= WINDOW_ADDR;
      pwdata  <= CSR_DATA_BITS'(value[WINDOW_BITS-1:0]);
      @(negedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      window_setting = value[WINDOW_BITS-1:0];
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      readback = prdata;
      if (readback !== CSR_DATA_BITS'(window_setting)) begin
         note_mismatch("window readback", 64'(window_setting), 64'(readback));
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // bar driver: bursts of random length, random gaps between them
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin : drive_bars
      bar_type next_bar;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || bar_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_bars.size() > 0) begin
            next_bar = pending_bars.pop_front();
            req_bus.high_price  <= next_bar.high_price;
            req_bus.low_price   <= next_bar.low_price;
            req_bus.close_price <= next_bar.close_price;
            req_bus.valid       <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 10);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // response stall pattern: rotate a 16-bit mask, reload it now and then
   // ------------------------------------------------------------------------
   logic [15:0] stall_mask = '1;
   int          mask_left  = 0;

   always @(negedge clock) begin
      if (mask_left == 0) begin
         case ($urandom_range(0, 3))
            0: stall_mask = '1;
            1: stall_mask = 16'($urandom()) | 16'h0001;
            2: stall_mask = 16'h0001 | (16'h0001 << $urandom_range(1, 15));
            default: stall_mask = (16'($urandom()) & 16'($urandom())) | 16'h0001;
         endcase
         mask_left = $urandom_range(16, 400);
      end else begin
         mask_left--;
      end
      rsp_bus.ready <= stall_mask[0];
      stall_mask = {stall_mask[0], stall_mask[15:1]};
   end

   // ------------------------------------------------------------------------
   // monitor: check each response beat, then predict for each accepted bar
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_beats
      vi_result_type want;
      if (reset) begin
         bar_taken = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_ratios.size() == 0) begin
               note_mismatch("unexpected response beat", '0, '0);
            end else begin
               want = expected_ratios.pop_front();
               if (rsp_bus.plus_index !== want.plus_index) begin
                  note_mismatch("plus_index", 64'(want.plus_index), 64'(rsp_bus.plus_index));
               end
               if (rsp_bus.minus_index !== want.minus_index) begin
                  note_mismatch("minus_index", 64'(want.minus_index),
                                64'(rsp_bus.minus_index));
               end
               if (TREND_BITS'(rsp_bus.trend_value) !== want.trend_value) begin
                  note_mismatch("trend_value", 64'(want.trend_value),
                                64'(TREND_BITS'(rsp_bus.trend_value)));
               end
               if (rsp_bus.ratio_valid !== want.ratio_valid) begin
                  note_mismatch("ratio_valid", 64'(want.ratio_valid),
                                64'(rsp_bus.ratio_valid));
               end
            end
         end
         bar_taken = req_bus.valid && req_bus.ready;
         if (bar_taken) begin
            expected_ratios.push_back(advance_vortex('{req_bus.high_price, req_bus.low_price,
                                                       req_bus.close_price}));
            bars_unaccepted--;
         end
      end
   end

   // ------------------------------------------------------------------------
   // phases: reset, directed bars at the reset window, then random phases
   // ------------------------------------------------------------------------
   int fixed_windows [9] = '{1, 64, 0, 127, 65, 2, 13, 40, 64};

   initial begin : run_phases
      int win;
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_bus.valid       = 1'b0;
      req_bus.high_price  = '0;
      req_bus.low_price   = '0;
      req_bus.close_price = '0;
      rsp_bus.ready       = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first bar, then flat bars whose range sum stays zero
      queue_bar(32'd5, 32'd5, 32'd5);
      queue_bar(32'd5, 32'd5, 32'd5);
      // close jumps away while the range stays zero
      queue_bar(32'd5, 32'd5, 32'd1000000);
      // tiny range against huge movement: both ratios saturate
      queue_bar(32'd1000001, 32'd1000000, 32'd1000000);
      queue_bar(32'd1000000, 32'd1000000, 32'd1000000);
      // low above high
      queue_bar(32'd10, 32'd20, 32'd15);
      // field extremes
      queue_bar('1, '0, '1);
      queue_bar('0, '1, '0);
      queue_bar('1, '1, '1);
      queue_bar('0, '0, '0);
      queue_bar('1, '0, '0);
      queue_bar('0, '0, '1);
      queue_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      // ordinary bars, rising then falling
      queue_bar(32'd1200, 32'd1100, 32'd1150);
      queue_bar(32'd1300, 32'd1180, 32'd1290);
      queue_bar(32'd1350, 32'd1250, 32'd1260);
      queue_bar(32'd1270, 32'd1100, 32'd1120);
      queue_bar(32'd1130, 32'd1000, 32'd1010);
      queue_bar(32'd1020, 32'd900, 32'd905);
      wait_idle();

      // reconfigure between phases; the window persists across the bar history
      for (int phase = 0; phase < 11; phase++) begin
         win = (phase < 9) ? fixed_windows[phase] : $urandom_range(0, 127);
         write_window(win);
         repeat (PHASE_BARS) begin
            pending_bars.push_back(random_bar());
            bars_unaccepted++;
         end
         wait_idle();
      end

      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_count == 0 && expected_ratios.size() == 0) begin
         $display("** vortex_indicator_window: PASSED **");
      end else begin
         $display("** vortex_indicator_window: FAILED **");
      end
      $finish;
   end

   // give up well past the slowest legitimate run
   initial begin
      #10_000_000;
      $display("** vortex_indicator_window: FAILED **");
      $finish;
   end

endmodule

[files.f]
rtl/vi_pkg.sv
rtl/vi_req_if.sv
rtl/vi_rsp_if.sv
rtl/vi_csr.sv
rtl/vi_history.sv
rtl/vi_divider.sv
rtl/vortex_indicator_window.sv
tb/sv/vortex_indicator_window_tb.sv
